### src/iso8601_basic_utc_to_epoch_seconds_assert.svh
// assertion macros shared by the timestamp converter modules
// expects signals named clock and reset in the including module
`ifndef ISO8601_BASIC_UTC_TO_EPOCH_SECONDS_ASSERT_SVH
`define ISO8601_BASIC_UTC_TO_EPOCH_SECONDS_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define ISOEP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("isoep: same-cycle check failed");

// condition holds in the cycle after the trigger
`define ISOEP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("isoep: next-cycle check failed");

`endif

### src/isoep_pkg.sv
// shared constants, types and the month table of the timestamp converter
// no dependencies
package isoep_pkg;

   localparam int CHAR_W  = 8;
   localparam int POS_W   = 5;
   localparam int YEAR_W  = 14;
   localparam int FIELD_W = 7;
   localparam int YOFF_W  = 7;
   localparam int DOY_W   = 9;
   localparam int DAY_W   = 15;
   localparam int TOD_W   = 17;
   localparam int SEC_W   = 32;

   localparam logic [POS_W-1:0] POS_SAT     = 5'd17;
   localparam logic [POS_W-1:0] STR_LEN     = 5'd16;
   localparam logic [POS_W-1:0] POS_T       = 5'd8;
   localparam logic [POS_W-1:0] POS_Z       = 5'd15;
   localparam logic [POS_W-1:0] POS_MONTH   = 5'd4;
   localparam logic [POS_W-1:0] POS_DAY     = 5'd6;
   localparam logic [POS_W-1:0] POS_MINUTE  = 5'd11;
   localparam logic [POS_W-1:0] POS_SECOND  = 5'd13;

   localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
   localparam logic [CHAR_W-1:0] CH_T    = 8'h54;
   localparam logic [CHAR_W-1:0] CH_Z    = 8'h5A;

   localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1970;
   localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd2038;
   localparam logic [FIELD_W-1:0] MONTH_MAX  = 7'd12;
   localparam logic [FIELD_W-1:0] DAY_MAX    = 7'd31;
   localparam logic [FIELD_W-1:0] HOUR_MAX   = 7'd24;
   localparam logic [FIELD_W-1:0] MINSEC_MAX = 7'd59;
   localparam logic [FIELD_W-1:0] FEBRUARY   = 7'd2;

   localparam logic [DAY_W-1:0] DAYS_PER_YEAR = 15'd365;
   localparam logic [TOD_W-1:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [TOD_W-1:0] SECS_PER_MIN  = 17'd60;
   localparam logic [SEC_W-1:0] SECS_PER_DAY  = 32'd86400;

   typedef enum logic [2:0] {
      ST_COLLECT = 3'b001,
      ST_CHECK   = 3'b010,
      ST_CONVERT = 3'b100
   } isoep_state_type;

   typedef struct packed {
      logic step;      // take one character
      logic capture;   // latch checks and day count, clear accumulators
      logic load_rsp;  // write the output register
   } isoep_cmd_type;

   // days in the year before the first of the month, non-leap
   function automatic logic [DOY_W-1:0] days_before_month(input logic [FIELD_W-1:0] month);
      logic [DOY_W-1:0] d;
      unique case (month)
         7'd1:    d = 9'd0;
         7'd2:    d = 9'd31;
         7'd3:    d = 9'd59;
         7'd4:    d = 9'd90;
         7'd5:    d = 9'd120;
         7'd6:    d = 9'd151;
         7'd7:    d = 9'd181;
         7'd8:    d = 9'd212;
         7'd9:    d = 9'd243;
         7'd10:   d = 9'd273;
         7'd11:   d = 9'd304;
         7'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

### src/isoep_req_if.sv
// character channel: one timestamp character per word
// depends on isoep_pkg
interface isoep_req_if import isoep_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              end_of_string;

   modport source (output valid, char_code, end_of_string, input ready);
   modport sink   (input valid, char_code, end_of_string, output ready);
endinterface

### src/isoep_rsp_if.sv
// result channel: epoch seconds and valid flag per word
// depends on isoep_pkg
interface isoep_rsp_if import isoep_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SEC_W-1:0] epoch_seconds;
   logic             valid_res;

   modport source (output valid, epoch_seconds, valid_res, input ready);
   modport sink   (input valid, epoch_seconds, valid_res, output ready);
endinterface

### src/isoep_datapath.sv
// field accumulators, format and range checks, epoch arithmetic, output register
// depends on isoep_pkg and the assertion macro header
`include "iso8601_basic_utc_to_epoch_seconds_assert.svh"

module isoep_datapath import isoep_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  isoep_cmd_type     cmd,
   input  logic [CHAR_W-1:0] char_code,
   output logic [SEC_W-1:0]  epoch_seconds,
   output logic              valid_res
);

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [FIELD_W-1:0] month_ff, month_in;
   logic [FIELD_W-1:0] day_ff, day_in;
   logic [FIELD_W-1:0] hour_ff, hour_in;
   logic [FIELD_W-1:0] minute_ff, minute_in;
   logic [FIELD_W-1:0] second_ff, second_in;
   logic               fmt_err_ff, fmt_err_in;

   logic               ok_ff, ok_in;
   logic [DAY_W-1:0]   days_ff, days_in;
   logic [TOD_W-1:0]   tod_ff, tod_in;
   logic [SEC_W-1:0]   epoch_ff, epoch_in;
   logic               vres_ff, vres_in;

   logic               is_digit;
   logic [CHAR_W-1:0]  digit_full;
   logic [3:0]         digit;
   logic [YEAR_W-1:0]  year_off;
   logic [YOFF_W-1:0]  yoff;
   logic               leap_add;
   logic [SEC_W-1:0]   secs;

   assign is_digit   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
   assign digit_full = char_code - CH_ZERO;
   assign digit      = digit_full[3:0];

   // character stepping and accumulation
   always_comb begin
      pos_in     = pos_ff;
      year_in    = year_ff;
      month_in   = month_ff;
      day_in     = day_ff;
      hour_in    = hour_ff;
      minute_in  = minute_ff;
      second_in  = second_ff;
      fmt_err_in = fmt_err_ff;
      if (cmd.capture) begin
         pos_in     = '0;
         year_in    = '0;
         month_in   = '0;
         day_in     = '0;
         hour_in    = '0;
         minute_in  = '0;
         second_in  = '0;
         fmt_err_in = 1'b0;
      end else if (cmd.step) begin
         pos_in = (pos_ff < POS_SAT) ? pos_ff + 5'd1 : POS_SAT;
         priority if (pos_ff >= STR_LEN) begin
            fmt_err_in = 1'b1;
         end else if (pos_ff == POS_T) begin
            if (char_code != CH_T) fmt_err_in = 1'b1;
         end else if (pos_ff == POS_Z) begin
            if (char_code != CH_Z) fmt_err_in = 1'b1;
         end else if (!is_digit) begin
            fmt_err_in = 1'b1;
         end else if (pos_ff < POS_MONTH) begin
            year_in = YEAR_W'(year_ff * 14'd10) + {10'd0, digit};
         end else if (pos_ff < POS_DAY) begin
            month_in = FIELD_W'(month_ff * 7'd10) + {3'd0, digit};
         end else if (pos_ff < POS_T) begin
            day_in = FIELD_W'(day_ff * 7'd10) + {3'd0, digit};
         end else if (pos_ff < POS_MINUTE) begin
            hour_in = FIELD_W'(hour_ff * 7'd10) + {3'd0, digit};
         end else if (pos_ff < POS_SECOND) begin
            minute_in = FIELD_W'(minute_ff * 7'd10) + {3'd0, digit};
         end else begin
            second_in = FIELD_W'(second_ff * 7'd10) + {3'd0, digit};
         end
      end
   end

   // first stage: checks, day count and time of day
   assign year_off = year_ff - YEAR_MIN;
   assign yoff     = year_off[YOFF_W-1:0];
   // leap years here are exactly those with year % 4 == 0, i.e. offset % 4 == 2
   assign leap_add = (month_ff > FEBRUARY) && (yoff[1:0] == 2'd2);

   always_comb begin
      ok_in = !fmt_err_ff && (pos_ff == STR_LEN)
           && (year_ff >= YEAR_MIN) && (year_ff <= YEAR_MAX)
           && (month_ff >= 7'd1) && (month_ff <= MONTH_MAX)
           && (day_ff >= 7'd1) && (day_ff <= DAY_MAX)
           && (hour_ff <= HOUR_MAX)
           && (minute_ff <= MINSEC_MAX)
           && (second_ff <= MINSEC_MAX);
      // leap days since 1970 before this year: (offset + 1) / 4
      days_in = DAY_W'(DAY_W'(yoff) * DAYS_PER_YEAR)
              + DAY_W'((yoff + 7'd1) >> 2)
              + DAY_W'(days_before_month(month_ff))
              + DAY_W'(leap_add)
              + DAY_W'(day_ff) - 15'd1;
      tod_in  = TOD_W'(TOD_W'(hour_ff) * SECS_PER_HOUR)
              + TOD_W'(TOD_W'(minute_ff) * SECS_PER_MIN)
              + TOD_W'(second_ff);
   end

   // second stage: scale days and add time of day
   assign secs     = SEC_W'(SEC_W'(days_ff) * SECS_PER_DAY) + SEC_W'(tod_ff);
   assign epoch_in = ok_ff ? secs : '0;
   assign vres_in  = ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         year_ff    <= '0;
         month_ff   <= '0;
         day_ff     <= '0;
         hour_ff    <= '0;
         minute_ff  <= '0;
         second_ff  <= '0;
         fmt_err_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         year_ff    <= year_in;
         month_ff   <= month_in;
         day_ff     <= day_in;
         hour_ff    <= hour_in;
         minute_ff  <= minute_in;
         second_ff  <= second_in;
         fmt_err_ff <= fmt_err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ok_ff   <= ok_in;
         days_ff <= days_in;
         tod_ff  <= tod_in;
      end
      if (cmd.load_rsp) begin
         epoch_ff <= epoch_in;
         vres_ff  <= vres_in;
      end
   end

   assign epoch_seconds = epoch_ff;
   assign valid_res     = vres_ff;

   `ISOEP_ASSERT_NEXT(a_capture_clears, cmd.capture, (pos_ff == '0) && !fmt_err_ff)
   `ISOEP_ASSERT_NOW(a_pos_saturates, 1'b1, pos_ff <= POS_SAT)

endmodule

### src/isoep_ctrl.sv
// sequencer: character collection, check stage, conversion and output hand-off
// depends on isoep_pkg and the assertion macro header
`include "iso8601_basic_utc_to_epoch_seconds_assert.svh"

module isoep_ctrl import isoep_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_end,
   output logic          req_ready,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output isoep_cmd_type cmd
);

   isoep_state_type state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            accept;
   logic            slot_free;

   assign req_ready = (state_ff == ST_COLLECT);
   assign accept    = req_valid && req_ready;
   // output register can take a word if empty or emptying this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cmd.step     = 1'b0;
      cmd.capture  = 1'b0;
      cmd.load_rsp = 1'b0;
      unique case (state_ff)
         ST_COLLECT: begin
            cmd.step = accept;
            if (accept && req_end) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.capture = 1'b1;
            state_in    = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `ISOEP_ASSERT_NEXT(a_end_to_check, accept && req_end, state_ff == ST_CHECK)
   `ISOEP_ASSERT_NEXT(a_check_to_convert, state_ff == ST_CHECK, state_ff == ST_CONVERT)
   `ISOEP_ASSERT_NEXT(a_convert_waits,
      (state_ff == ST_CONVERT) && rsp_valid_ff && !rsp_ready,
      (state_ff == ST_CONVERT) && rsp_valid_ff)

endmodule

### src/iso8601_basic_utc_to_epoch_seconds.sv
// top level: CCYYMMDDThhmmssZ character stream to UTC seconds since 1970
// depends on isoep_pkg, isoep_req_if, isoep_rsp_if, isoep_ctrl, isoep_datapath
//
//   channel   dir   word
//   req_ch    in    char_code[7:0], end_of_string
//   rsp_ch    out   epoch_seconds[31:0], valid_res
//
// one character per cycle while collecting; no result for characters without the end flag
// after the end flag: a check state, then a multiply state that registers the result
// input is held off in both states, and longer while a previous result is not taken
// a waiting result does not block characters of the next string
// reset is synchronous and clears position, accumulators and the output valid

module iso8601_basic_utc_to_epoch_seconds import isoep_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   isoep_req_if.sink          req_ch,
   isoep_rsp_if.source        rsp_ch
);

   isoep_cmd_type cmd;

   isoep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_end   (req_ch.end_of_string),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .cmd       (cmd)
   );

   isoep_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .char_code     (req_ch.char_code),
      .epoch_seconds (rsp_ch.epoch_seconds),
      .valid_res     (rsp_ch.valid_res)
   );

endmodule
